/* sv/mnct_pkg.sv */
// Shared types, codes and the message length decode for the MIDI tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mnct_pkg;

   // Fixed field widths
   localparam int BYTE_BITS      = 8;
   localparam int DATA_BITS      = 7;
   localparam int CHANNEL_BITS   = 4;
   localparam int OUT_COUNT_BITS = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LISTEN_CHANNEL     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRACKED_CONTROLLER = 2'd1;

   // Status and message kind codes
   localparam logic [BYTE_BITS-1:0] TICK_STATUS   = 8'hF8;
   localparam logic [BYTE_BITS-1:0] SONG_POSITION = 8'hF2;
   localparam logic [BYTE_BITS-1:0] TIME_CODE     = 8'hF1;
   localparam logic [BYTE_BITS-1:0] SONG_SELECT   = 8'hF3;
   localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON   = 4'h9;
   localparam logic [3:0] KIND_POLY_PRES = 4'hA;
   localparam logic [3:0] KIND_CONTROL   = 4'hB;
   localparam logic [3:0] KIND_PROGRAM   = 4'hC;
   localparam logic [3:0] KIND_CHAN_PRES = 4'hD;
   localparam logic [3:0] KIND_BEND      = 4'hE;

   // Reset values
   localparam logic [DATA_BITS-1:0] NOTE_AT_RESET       = 7'd60;
   localparam logic [DATA_BITS-1:0] CONTROLLER_AT_RESET = 7'd74;

   // Message length in bytes
   typedef enum logic [1:0] {
      LEN_ONE   = 2'd1,
      LEN_TWO   = 2'd2,
      LEN_THREE = 2'd3
   } msg_len_type;

   // A completed message handed from the framer to the tracker
   typedef struct packed {
      logic                 complete;
      logic [BYTE_BITS-1:0] status;
      logic [DATA_BITS-1:0] data1;
      logic [DATA_BITS-1:0] data2;
   } msg_type;

   // Length of a message opened by status byte st
   function automatic msg_len_type msg_len(input logic [BYTE_BITS-1:0] st);
      msg_len_type len;
      case (st[7:4])
         KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_PRES, KIND_CONTROL, KIND_BEND: begin
            len = LEN_THREE;
         end
         KIND_PROGRAM, KIND_CHAN_PRES: begin
            len = LEN_TWO;
         end
         default: begin
            if (st == TIME_CODE || st == SONG_SELECT) begin
               len = LEN_TWO;
            end else if (st == SONG_POSITION) begin
               len = LEN_THREE;
            end else begin
               len = LEN_ONE;
            end
         end
      endcase
      return len;
   endfunction

endpackage

/* sv/mnct_framer.sv */
// Message framer: gathers stream bytes into complete MIDI messages.
// Depends on mnct_pkg.
`timescale 1ns / 1ps

module mnct_framer
   import mnct_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [BYTE_BITS-1:0] midi_byte,
   output msg_type              msg
);

   logic [BYTE_BITS-1:0] open_status_ff, open_status_in;
   logic [DATA_BITS-1:0] first_data_ff, first_data_in;
   logic [1:0]           bytes_collected_ff, bytes_collected_in;
   logic [DATA_BITS-1:0] masked_data;

   assign masked_data = midi_byte[DATA_BITS-1:0];

   // Framing decision for the byte in hand
   always_comb begin
      open_status_in     = open_status_ff;
      first_data_in      = first_data_ff;
      bytes_collected_in = bytes_collected_ff;
      msg                = '0;
      if (bytes_collected_ff == 2'd0) begin
         // no message open: stray data is dropped
         if (midi_byte[7]) begin
            if (msg_len(midi_byte) == LEN_ONE) begin
               msg.complete = 1'b1;
               msg.status   = midi_byte;
            end else begin
               open_status_in     = midi_byte;
               bytes_collected_in = 2'd1;
            end
         end
      end else if (bytes_collected_ff == 2'd1 && msg_len(open_status_ff) == LEN_THREE) begin
         first_data_in      = masked_data;
         bytes_collected_in = 2'd2;
      end else begin
         msg.complete       = 1'b1;
         msg.status         = open_status_ff;
         msg.data1          = (bytes_collected_ff == 2'd1) ? masked_data : first_data_ff;
         msg.data2          = (bytes_collected_ff == 2'd1) ? '0 : masked_data;
         open_status_in     = '0;
         bytes_collected_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_status_ff     <= '0;
         first_data_ff      <= '0;
         bytes_collected_ff <= 2'd0;
      end else if (fire) begin
         open_status_ff     <= open_status_in;
         first_data_ff      <= first_data_in;
         bytes_collected_ff <= bytes_collected_in;
      end
   end

   // A message never holds more than two bytes before completing
   assert property (@(posedge clock) disable iff (reset) bytes_collected_ff != 2'd3)
      else $error("framer byte count out of range");

   // Two bytes held only for a three-byte message
   assert property (@(posedge clock) disable iff (reset)
         bytes_collected_ff == 2'd2 |-> msg_len(open_status_ff) == LEN_THREE)
      else $error("framer holds two bytes of a short message");

endmodule

/* sv/mnct_tracker.sv */
// Tracker state: held note, last note, controller value and event counters.
// Depends on mnct_pkg; fed by mnct_framer.
`timescale 1ns / 1ps

module mnct_tracker
   import mnct_pkg::*;
#(
   parameter int COUNTER_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  msg_type                   msg,
   input  logic [CHANNEL_BITS-1:0]   listen_channel,
   input  logic [DATA_BITS-1:0]      tracked_controller,
   output logic                      note_is_on,
   output logic [DATA_BITS-1:0]      active_note,
   output logic [DATA_BITS-1:0]      previous_note,
   output logic [DATA_BITS-1:0]      controller_value,
   output logic [OUT_COUNT_BITS-1:0] note_on_total,
   output logic [OUT_COUNT_BITS-1:0] clock_ticks
);

   logic                    note_held_ff, note_held_in;
   logic [DATA_BITS-1:0]    held_note_ff, held_note_in;
   logic [DATA_BITS-1:0]    prev_note_ff, prev_note_in;
   logic [DATA_BITS-1:0]    control_value_ff, control_value_in;
   logic [COUNTER_BITS-1:0] note_on_count_ff, note_on_count_in;
   logic [COUNTER_BITS-1:0] tick_count_ff, tick_count_in;
   logic [3:0]              kind;
   logic                    on_channel;

   assign kind       = msg.status[7:4];
   assign on_channel = (msg.status[3:0] == listen_channel);

   // Act on a completed message
   always_comb begin
      note_held_in     = note_held_ff;
      held_note_in     = held_note_ff;
      prev_note_in     = prev_note_ff;
      control_value_in = control_value_ff;
      note_on_count_in = note_on_count_ff;
      tick_count_in    = tick_count_ff;
      if (msg.complete) begin
         if (msg.status == TICK_STATUS) begin
            tick_count_in = tick_count_ff + COUNTER_BITS'(1);
         end else if (on_channel) begin
            case (kind)
               KIND_NOTE_ON: begin
                  if (msg.data2 == '0) begin
                     if (note_held_ff && msg.data1 == held_note_ff) begin
                        note_held_in = 1'b0;
                     end
                  end else begin
                     note_held_in     = 1'b1;
                     held_note_in     = msg.data1;
                     prev_note_in     = msg.data1;
                     note_on_count_in = note_on_count_ff + COUNTER_BITS'(1);
                  end
               end
               KIND_NOTE_OFF: begin
                  if (note_held_ff && msg.data1 == held_note_ff) begin
                     note_held_in = 1'b0;
                  end
               end
               KIND_CONTROL: begin
                  if (msg.data1 == tracked_controller) begin
                     control_value_in = msg.data2;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         note_held_ff     <= 1'b0;
         held_note_ff     <= NOTE_AT_RESET;
         prev_note_ff     <= NOTE_AT_RESET;
         control_value_ff <= '0;
         note_on_count_ff <= '0;
         tick_count_ff    <= '0;
      end else if (fire) begin
         note_held_ff     <= note_held_in;
         held_note_ff     <= held_note_in;
         prev_note_ff     <= prev_note_in;
         control_value_ff <= control_value_in;
         note_on_count_ff <= note_on_count_in;
         tick_count_ff    <= tick_count_in;
      end
   end

   // State registers double as the result register
   assign note_is_on       = note_held_ff;
   assign active_note      = held_note_ff;
   assign previous_note    = prev_note_ff;
   assign controller_value = control_value_ff;

   // Counters show their low output bits, zero-extended when narrower
   generate
      if (COUNTER_BITS >= OUT_COUNT_BITS) begin : g_wide
         assign note_on_total = note_on_count_ff[OUT_COUNT_BITS-1:0];
         assign clock_ticks   = tick_count_ff[OUT_COUNT_BITS-1:0];
      end else begin : g_narrow
         assign note_on_total = {{(OUT_COUNT_BITS-COUNTER_BITS){1'b0}}, note_on_count_ff};
         assign clock_ticks   = {{(OUT_COUNT_BITS-COUNTER_BITS){1'b0}}, tick_count_ff};
      end
   endgenerate

   // Tracker state moves only when a word is processed
   assert property (@(posedge clock) disable iff (reset)
         !fire |=> $stable(tick_count_ff) && $stable(note_on_count_ff))
      else $error("tracker counters moved without a word");

   // Note goes on only through a note-on message
   assert property (@(posedge clock) disable iff (reset)
         !(fire && msg.complete && kind == KIND_NOTE_ON) |=> !$rose(note_held_ff))
      else $error("note held without a note-on");

endmodule

/* sv/midi_note_cc_clock_tracker.sv */
// MIDI byte-stream tracker: one byte in per word, one tracker snapshot out per word.
//
// Input channel (req_): one raw MIDI byte per word. Status bytes open messages
// of 1, 2 or 3 bytes; stray data bytes with no open message are dropped.
// Result channel (rsp_): held-note flag, active and previous note, tracked
// controller value and the note-on and clock-tick counts after that byte.
// Config port (csr_): index 0 listen channel, index 1 tracked controller;
// always ready; the user must write it only while the block is idle (not enforced).
//
// A byte accepted into the input register is processed when the result side is free,
// and its result is valid from then on. Throughput: one byte per cycle while the
// result is not stalled; the decode lies between input register and tracker state.
// While rsp_stall is high the result holds and one more byte is taken into the
// input register; after that req_stall rises until the result is taken.
// Reset (synchronous) clears the framer, notes to 60, controller value and
// counters to 0, listen channel to 0 and tracked controller to 74.
`timescale 1ns / 1ps

module midi_note_cc_clock_tracker
   import mnct_pkg::*;
#(
   parameter int COUNTER_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // input channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [BYTE_BITS-1:0]      req_midi_byte,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_note_is_on,
   output logic [DATA_BITS-1:0]      rsp_active_note,
   output logic [DATA_BITS-1:0]      rsp_previous_note,
   output logic [DATA_BITS-1:0]      rsp_controller_value,
   output logic [OUT_COUNT_BITS-1:0] rsp_note_on_total,
   output logic [OUT_COUNT_BITS-1:0] rsp_clock_ticks,
   // configuration port
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                    byte_valid_ff, byte_valid_in;
   logic [BYTE_BITS-1:0]    byte_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_BITS-1:0] listen_channel_ff;
   logic [DATA_BITS-1:0]    tracked_controller_ff;
   logic                    advance;
   msg_type                 msg;

   // Pipeline control
   assign advance   = byte_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = byte_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      byte_valid_in = byte_valid_ff;
      if (!req_stall) begin
         byte_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Input word register
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_midi_byte;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         listen_channel_ff     <= '0;
         tracked_controller_ff <= CONTROLLER_AT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LISTEN_CHANNEL: begin
               listen_channel_ff <= csr_wdata[CHANNEL_BITS-1:0];
            end
            CSR_TRACKED_CONTROLLER: begin
               tracked_controller_ff <= csr_wdata[DATA_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   mnct_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .midi_byte (byte_ff),
      .msg       (msg)
   );

   mnct_tracker #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_tracker (
      .clock              (clock),
      .reset              (reset),
      .fire               (advance),
      .msg                (msg),
      .listen_channel     (listen_channel_ff),
      .tracked_controller (tracked_controller_ff),
      .note_is_on         (rsp_note_is_on),
      .active_note        (rsp_active_note),
      .previous_note      (rsp_previous_note),
      .controller_value   (rsp_controller_value),
      .note_on_total      (rsp_note_on_total),
      .clock_ticks        (rsp_clock_ticks)
   );

   // Input stalls only with a full input register behind a blocked result
   assert property (@(posedge clock) disable iff (reset)
         req_stall |-> byte_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

endmodule

/* bench/testbench.sv */
// Self-checking bench for the MIDI note, controller and clock tracker.
// Depends on mnct_pkg and midi_note_cc_clock_tracker; drives directed and random
// byte streams against an in-bench tracker model and checks every snapshot word.
`timescale 1ns / 1ps

module testbench;
   import mnct_pkg::*;

   localparam int COUNTER_BITS    = 32;
   localparam int BYTES_PER_PHASE = 220;
   localparam int PHASES          = 5;
   localparam int MAX_WAIT        = 13;
   localparam int IDLE_LIMIT      = 400;
   localparam int REPORT_LIMIT    = 10;

   // Index values past the register list; writes there must do nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   localparam logic [3:0]           KIND_SYSTEM  = 4'hF;
   localparam logic [BYTE_BITS-1:0] SYSTEM_RESET = 8'hFF;

   // One tracker snapshot, as carried by a result word
   typedef struct packed {
      logic                      note_is_on;
      logic [DATA_BITS-1:0]      active_note;
      logic [DATA_BITS-1:0]      previous_note;
      logic [DATA_BITS-1:0]      controller_value;
      logic [OUT_COUNT_BITS-1:0] note_on_total;
      logic [OUT_COUNT_BITS-1:0] clock_ticks;
   } snapshot_type;

   // Directed stimulus row; typed rows carry a hand-written snapshot
   typedef struct {
      logic [BYTE_BITS-1:0] midi;
      bit                   typed;
      snapshot_type         want;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [BYTE_BITS-1:0]      req_midi_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_note_is_on;
   logic [DATA_BITS-1:0]      rsp_active_note;
   logic [DATA_BITS-1:0]      rsp_previous_note;
   logic [DATA_BITS-1:0]      rsp_controller_value;
   logic [OUT_COUNT_BITS-1:0] rsp_note_on_total;
   logic [OUT_COUNT_BITS-1:0] rsp_clock_ticks;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   midi_note_cc_clock_tracker #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_midi_byte        (req_midi_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_note_is_on       (rsp_note_is_on),
      .rsp_active_note      (rsp_active_note),
      .rsp_previous_note    (rsp_previous_note),
      .rsp_controller_value (rsp_controller_value),
      .rsp_note_on_total    (rsp_note_on_total),
      .rsp_clock_ticks      (rsp_clock_ticks),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Tracker model state and its copy of the registers
   logic [3:0]              listen_chan = 4'd0;
   logic [DATA_BITS-1:0]    watch_cc = CONTROLLER_AT_RESET;
   logic [BYTE_BITS-1:0]    open_status = '0;
   logic [DATA_BITS-1:0]    first_data = '0;
   logic [1:0]              collected = '0;
   logic                    note_held = 1'b0;
   logic [DATA_BITS-1:0]    held_note = NOTE_AT_RESET;
   logic [DATA_BITS-1:0]    recent_note = NOTE_AT_RESET;
   logic [DATA_BITS-1:0]    cc_value = '0;
   logic [COUNTER_BITS-1:0] note_ons = '0;
   logic [COUNTER_BITS-1:0] ticks = '0;

   snapshot_type         pending_snapshots[$];
   logic [BYTE_BITS-1:0] burst[$];
   stim_row_type         directed_rows[$];

   bit idle_on = 1'b1;
   int framed_bytes = 0;
   int bytes_sent = 0;
   int snapshots_checked = 0;
   int reg_writes = 0;
   int errors = 0;
   int idle_cycles = 0;

   // Message length in bytes for a status byte
   function automatic int msg_length(input logic [BYTE_BITS-1:0] st);
      if (st[7:4] != KIND_SYSTEM) begin
         return (st[7:4] == KIND_PROGRAM || st[7:4] == KIND_CHAN_PRES) ? 2 : 3;
      end
      if (st == TIME_CODE || st == SONG_SELECT) return 2;
      return (st == SONG_POSITION) ? 3 : 1;
   endfunction

   // Act on one complete message
   function automatic void apply_message(input logic [BYTE_BITS-1:0] st,
                                         input logic [DATA_BITS-1:0] d1,
                                         input logic [DATA_BITS-1:0] d2);
      if (st == TICK_STATUS) begin
         ticks = ticks + 1'b1;
         return;
      end
      if (st[3:0] != listen_chan) return;
      if (st[7:4] == KIND_NOTE_ON && d2 != '0) begin
         note_held   = 1'b1;
         held_note   = d1;
         recent_note = d1;
         note_ons    = note_ons + 1'b1;
      end else if (st[7:4] == KIND_NOTE_ON || st[7:4] == KIND_NOTE_OFF) begin
         if (note_held && d1 == held_note) note_held = 1'b0;
      end else if (st[7:4] == KIND_CONTROL && d1 == watch_cc) begin
         cc_value = d2;
      end
   endfunction

   // Feed one byte to the model and return the snapshot after it
   function automatic snapshot_type track_byte(input logic [BYTE_BITS-1:0] b);
      snapshot_type s;
      if (collected == 2'd0) begin
         if (b[7]) begin
            framed_bytes++;
            if (msg_length(b) == 1) begin
               apply_message(b, '0, '0);
            end else begin
               open_status = b;
               collected   = 2'd1;
            end
         end
      end else begin
         // any byte fills an open message, masked to data width
         framed_bytes++;
         if (collected == 2'd1 && msg_length(open_status) == 3) begin
            first_data = b[DATA_BITS-1:0];
            collected  = 2'd2;
         end else begin
            if (collected == 2'd1) apply_message(open_status, b[DATA_BITS-1:0], '0);
            else apply_message(open_status, first_data, b[DATA_BITS-1:0]);
            open_status = '0;
            collected   = 2'd0;
         end
      end
      s.note_is_on       = note_held;
      s.active_note      = held_note;
      s.previous_note    = recent_note;
      s.controller_value = cc_value;
      s.note_on_total    = note_ons[OUT_COUNT_BITS-1:0];
      s.clock_ticks      = ticks[OUT_COUNT_BITS-1:0];
      return s;
   endfunction

   function automatic snapshot_type snap(input logic on, input int act, input int prev,
                                         input int cc, input int ons, input int clk_ticks);
      snapshot_type s;
      s.note_is_on       = on;
      s.active_note      = act[DATA_BITS-1:0];
      s.previous_note    = prev[DATA_BITS-1:0];
      s.controller_value = cc[DATA_BITS-1:0];
      s.note_on_total    = ons;
      s.clock_ticks      = clk_ticks;
      return s;
   endfunction

   function automatic logic [BYTE_BITS-1:0] status_of(input logic [3:0] kind,
                                                      input logic [3:0] chan);
      return {kind, chan};
   endfunction

   function automatic void add_row(input logic [BYTE_BITS-1:0] midi, input bit typed,
                                   input snapshot_type want);
      stim_row_type r;
      r.midi  = midi;
      r.typed = typed;
      r.want  = want;
      directed_rows.push_back(r);
   endfunction

   function automatic int draw_wait();
      return idle_on ? $urandom_range(0, MAX_WAIT) : 0;
   endfunction

   // Mostly held notes and extremes, so releases find a match
   function automatic logic [DATA_BITS-1:0] pick_note();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return held_note;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   function automatic logic [DATA_BITS-1:0] pick_data();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   // Append one random message, or noise, to the burst queue
   function automatic void queue_random_message();
      logic [3:0] chan;
      logic [3:0] kind;
      int         pick;
      chan = ($urandom_range(0, 3) != 0) ? listen_chan : 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         burst.push_back(status_of(KIND_NOTE_ON, chan));
         burst.push_back({1'b0, pick_note()});
         burst.push_back({1'b0, ($urandom_range(0, 3) == 0) ? 7'd0 : pick_data()});
      end else if (pick < 45) begin
         burst.push_back(status_of(KIND_NOTE_OFF, chan));
         burst.push_back({1'b0, pick_note()});
         burst.push_back({1'b0, pick_data()});
      end else if (pick < 58) begin
         burst.push_back(status_of(KIND_CONTROL, chan));
         burst.push_back({1'b0, ($urandom_range(0, 4) < 3) ? watch_cc : pick_data()});
         burst.push_back({1'b0, pick_data()});
      end else if (pick < 68) begin
         burst.push_back(TICK_STATUS);
      end else if (pick < 76) begin
         // other voice messages, consumed at their length
         case ($urandom_range(0, 3))
            0: kind = KIND_POLY_PRES;
            1: kind = KIND_PROGRAM;
            2: kind = KIND_CHAN_PRES;
            default: kind = KIND_BEND;
         endcase
         burst.push_back(status_of(kind, chan));
         burst.push_back({1'b0, pick_data()});
         if (msg_length(status_of(kind, chan)) == 3) burst.push_back({1'b0, pick_data()});
      end else if (pick < 84) begin
         // system common and real-time bytes
         burst.push_back(status_of(KIND_SYSTEM, 4'($urandom_range(0, 15))));
         repeat (msg_length(burst[$]) - 1) burst.push_back({1'b0, pick_data()});
      end else if (pick < 93) begin
         burst.push_back(8'($urandom_range(0, 255)));
      end else begin
         // status inside an open message
         burst.push_back(status_of(4'($urandom_range(8, 15)), chan));
         repeat ($urandom_range(1, 3)) burst.push_back(8'($urandom_range(128, 255)));
      end
   endfunction

   // Present one byte, hold it until taken, then record its snapshot
   task automatic send_byte(input logic [BYTE_BITS-1:0] b, input bit typed,
                            input snapshot_type want);
      int           gap;
      snapshot_type predicted;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_midi_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = track_byte(b);
      pending_snapshots.push_back(typed ? want : predicted);
      bytes_sent++;
   endtask

   // One register write; valid stays high for a following write
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] wdata);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         CSR_LISTEN_CHANNEL:     listen_chan = wdata[3:0];
         CSR_TRACKED_CONTROLLER: watch_cc = wdata[DATA_BITS-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic drain_results();
      while (pending_snapshots.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [OUT_COUNT_BITS-1:0] want,
                              input logic [OUT_COUNT_BITS-1:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("mismatch in word %0d: %s expected 0x%0h, got 0x%0h",
                     snapshots_checked, name, want, got);
      end
   endtask

   // Result side: random stall before each word while idling is on
   initial begin : result_sink
      int hold;
      forever begin
         hold = draw_wait();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (reset || !(rsp_valid === 1'b1 && !rsp_stall));
      end
   end

   // Compare each taken word with the oldest snapshot waiting
   always @(posedge clock) begin : check_words
      snapshot_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_snapshots.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) $display("result word with no snapshot waiting");
         end else begin
            want = pending_snapshots.pop_front();
            check_field("note_is_on", want.note_is_on, rsp_note_is_on);
            check_field("active_note", want.active_note, rsp_active_note);
            check_field("previous_note", want.previous_note, rsp_previous_note);
            check_field("controller_value", want.controller_value, rsp_controller_value);
            check_field("note_on_total", want.note_on_total, rsp_note_on_total);
            check_field("clock_ticks", want.clock_ticks, rsp_clock_ticks);
            snapshots_checked++;
         end
      end
   end

   // Cycles since any word moved
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
          (csr_valid && csr_ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("no word moved for %0d cycles", IDLE_LIMIT);
      $display("[midi_note_cc_clock_tracker] ERROR");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int start;
      snapshot_type none;
      none = '0;

      // Directed: reset state, stray data, one-byte messages, note extremes,
      // velocity-zero release, status taken as data, other message lengths
      add_row(8'h00, 1, snap(0, 60, 60, 0, 0, 0));
      add_row(SYSTEM_RESET, 1, snap(0, 60, 60, 0, 0, 0));
      add_row(TICK_STATUS, 1, snap(0, 60, 60, 0, 0, 1));
      add_row(status_of(KIND_NOTE_ON, 4'd0), 1, snap(0, 60, 60, 0, 0, 1));
      add_row(8'h7F, 1, snap(0, 60, 60, 0, 0, 1));
      add_row(8'h7F, 1, snap(1, 127, 127, 0, 1, 1));
      add_row(status_of(KIND_NOTE_OFF, 4'd0), 0, none);
      add_row(8'h7F, 0, none);
      add_row(8'h00, 1, snap(0, 127, 127, 0, 1, 1));
      add_row(status_of(KIND_CONTROL, 4'd0), 0, none);
      add_row({1'b0, CONTROLLER_AT_RESET}, 0, none);
      add_row(8'hFF, 1, snap(0, 127, 127, 127, 1, 1));
      add_row(status_of(KIND_NOTE_ON, 4'd0), 0, none);
      add_row(8'h00, 0, none);
      add_row(8'h01, 0, none);
      add_row(status_of(KIND_NOTE_ON, 4'd0), 0, none);
      add_row(8'h00, 0, none);
      add_row(8'h00, 0, none);
      add_row(SONG_POSITION, 0, none);
      add_row(8'h01, 0, none);
      add_row(8'h02, 0, none);
      add_row(status_of(KIND_PROGRAM, 4'd5), 0, none);
      add_row(8'h10, 0, none);
      add_row(TIME_CODE, 0, none);
      add_row(8'h80, 0, none);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].midi, directed_rows[i].typed, directed_rows[i].want);

      // Random phases, each under its own register setting
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            // input goes quiet so nothing is in flight during the writes
            req_valid <= 1'b0;
            drain_results();
            case (phase)
               1: begin
                  write_reg(CSR_LISTEN_CHANNEL, 8'hFF);
                  write_reg(CSR_TRACKED_CONTROLLER, 8'hFF);
               end
               2: begin
                  write_reg(CSR_LISTEN_CHANNEL, 8'h00);
                  write_reg(CSR_TRACKED_CONTROLLER, 8'h80);
               end
               3: begin
                  write_reg(CSR_SPARE_A, 8'($urandom_range(0, 255)));
                  write_reg(CSR_LISTEN_CHANNEL, 8'($urandom_range(0, 255)));
                  write_reg(CSR_TRACKED_CONTROLLER, 8'($urandom_range(0, 255)));
               end
               default: begin
                  write_reg(CSR_SPARE_B, 8'($urandom_range(0, 255)));
                  write_reg(CSR_TRACKED_CONTROLLER, {1'b0, CONTROLLER_AT_RESET});
                  write_reg(CSR_LISTEN_CHANNEL, 8'($urandom_range(0, 255)));
               end
            endcase
            csr_valid <= 1'b0;
         end
         // one phase runs both sides with no idling
         idle_on = (phase != 2);
         start = framed_bytes;
         while (framed_bytes - start < BYTES_PER_PHASE) begin
            queue_random_message();
            while (burst.size() != 0) send_byte(burst.pop_front(), 0, none);
         end
      end
      req_valid <= 1'b0;

      drain_results();
      $display("sent %0d bytes in %0d register settings, %0d register writes",
               bytes_sent, PHASES, reg_writes);
      $display("checked %0d snapshots; model saw %0d note-ons and %0d clock ticks",
               snapshots_checked, note_ons, ticks);
      if (errors == 0 && pending_snapshots.size() == 0) begin
         $display("[midi_note_cc_clock_tracker] OK");
      end else begin
         $display("%0d mismatches, %0d snapshots never arrived", errors,
                  pending_snapshots.size());
         $display("[midi_note_cc_clock_tracker] ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
sv/mnct_pkg.sv
sv/mnct_framer.sv
sv/mnct_tracker.sv
sv/midi_note_cc_clock_tracker.sv
bench/testbench.sv
